>>> hw/rtl/whs_pkg.sv
// Shared types and constants for the wave height stencil step core.
// Line-memory entry layout, result record and configuration register indexes.
// No dependencies.
`default_nettype none

package whs_pkg;

  localparam int HGT_W      = 24;
  localparam int DEP_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ROW  = 3'd4;

  localparam logic [10:0] GRID_WIDTH_RST  = 11'd1024;
  localparam logic [15:0] GRID_HEIGHT_RST = 16'd1024;

  // One column of the line buffers: rows above and two above.
  typedef struct packed {
    logic        [DEP_W-1:0] dep_two;
    logic        [DEP_W-1:0] dep_up;
    logic signed [HGT_W-1:0] bef_up;
    logic signed [HGT_W-1:0] now_two;
    logic signed [HGT_W-1:0] now_up;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic signed [HGT_W-1:0] height_next;
    logic                    last_of_run;
    logic                    frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/whs_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module whs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/whs_outq.sv
// Two-entry result queue in front of the output stream.
// Takes one or two results per push; depends on whs_pkg.
`default_nettype none

module whs_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire whs_pkg::result_t  push_a_i,
  input  wire whs_pkg::result_t  push_b_i,
  output logic      [1:0]        free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output whs_pkg::result_t       data_o
);

  whs_pkg::result_t ent0_q, ent0_d, ent1_q, ent1_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign free_o  = 2'd2 - cnt_q;
  assign data_o  = ent0_q;

  // a two-result push only comes when the queue is empty
  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    cnt_d  = cnt_q;
    if (pop) begin
      ent0_d = ent1_q;
      cnt_d  = cnt_q - 2'd1;
    end
    if (push_n_i != 2'd0) begin
      if (cnt_d == 2'd0) begin
        ent0_d = push_a_i;
      end else begin
        ent1_d = push_a_i;
      end
      cnt_d = cnt_d + 2'd1;
    end
    if (push_n_i == 2'd2) begin
      ent1_d = push_b_i;
      cnt_d  = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/wave_height_stencil_step_core.sv
// One time step of a 2D finite-difference shallow-water wave update. Cells of current height,
// previous height and depth stream in raster order; a line memory of MAX_WIDTH columns holds
// the two rows above, so results lag the input by one row (last-row cells give a second,
// zero result). An interior cell passes from request to queued result through accept,
// memory read and write-back, stencil products, sum, split coefficient multiply, rounding
// add and saturate; first-row cells end after the read, border and source cells skip to
// the final state. A single-cell sequencer runs around the one line memory. After reset a
// clearing pass zeroes the line memory; no request is taken meanwhile, configuration writes
// are. Results sit in a two-entry queue, so a new cell is taken while results wait on the
// output, once the queue has had room for the previous cell's results.
`default_nettype none

module wave_height_stencil_step_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [whs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [whs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // cell input
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [23:0] height_now, [47:24] height_before, [63:48] sea_depth, [87:64] source_value
  input  wire logic [87:0]                        s_axis_tdata,
  // result output
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [23:0] height_next
  output logic [23:0]                             m_axis_tdata,
  output logic                                    m_axis_tlast,
  // [0] frame_end
  output logic [0:0]                              m_axis_tuser
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam logic [80:0]        RND_HALF = 81'h2_0000_0000;
  localparam logic signed [46:0] SAT_MAX  = 47'sd8388607;
  localparam logic signed [46:0] SAT_MIN  = -47'sd8388608;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_MUL1, ST_SUM, ST_MUL2, ST_ADD, ST_FIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [10:0] gw_q;
  logic [15:0] gh_q;
  logic [31:0] coef_q;
  logic [9:0]  scol_q;
  logic [15:0] srow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= whs_pkg::GRID_WIDTH_RST;
      gh_q   <= whs_pkg::GRID_HEIGHT_RST;
      coef_q <= '0;
      scol_q <= '0;
      srow_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        whs_pkg::CFG_GRID_WIDTH:  gw_q   <= cfg_wdata_i[10:0];
        whs_pkg::CFG_GRID_HEIGHT: gh_q   <= cfg_wdata_i[15:0];
        whs_pkg::CFG_WAVE_COEF:   coef_q <= cfg_wdata_i[31:0];
        whs_pkg::CFG_SOURCE_COL:  scol_q <= cfg_wdata_i[9:0];
        whs_pkg::CFG_SOURCE_ROW:  srow_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [EW-1:0] gw_x, w_eff;
  logic [15:0]   h_eff;

  always_comb begin
    gw_x = EW'(gw_q);
    if (gw_x < EW'(3)) begin
      w_eff = EW'(3);
    end else if (gw_x > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = gw_x;
    end
    h_eff = (gh_q < 16'd3) ? 16'd3 : gh_q;
  end

  // raster position of the incoming cell and of the one after it
  logic [CW-1:0] col_q, c0, c1;
  logic [15:0]   row_q, r0, r1;
  logic [16:0]   r0x, r1x;
  logic [EW-1:0] c0n;
  logic [1:0]    n_res;
  logic          border, source, last_row, last_col;

  always_comb begin
    if (EW'(col_q) >= w_eff) begin
      c0  = '0;
      r0x = {1'b0, row_q} + 17'd1;
    end else begin
      c0  = col_q;
      r0x = {1'b0, row_q};
    end
    r0  = (r0x >= {1'b0, h_eff}) ? 16'd0 : r0x[15:0];
    c0n = EW'(c0) + EW'(1);
    r1x = {1'b0, r0} + 17'd1;
    if (c0n >= w_eff) begin
      c1 = '0;
      r1 = (r1x >= {1'b0, h_eff}) ? 16'd0 : r1x[15:0];
    end else begin
      c1 = c0n[CW-1:0];
      r1 = r0;
    end
    last_row = (r0 == h_eff - 16'd1);
    last_col = (EW'(c0) == w_eff - EW'(1));
    // output row is r0 - 1
    border   = (r0 == 16'd1) || (c0 == '0) || last_col;
    source   = (r0 - 16'd1 == srow_q) && (EW'(c0) == EW'(scol_q));
    if (r0 == 16'd0) begin
      n_res = 2'd0;
    end else begin
      n_res = last_row ? 2'd2 : 2'd1;
    end
  end

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // line memory
  whs_pkg::line_t    ra, rb, wline;
  logic [whs_pkg::LINE_W-1:0] rdata_a, rdata_b;
  logic              ram_we;
  logic [CW-1:0]     ram_waddr, clr_q, c_q;

  logic signed [23:0] cur_q, prv_q, src_q, upl_now_q;
  logic        [15:0] dep_q, upl_dep_q;
  logic [1:0]         n_q;
  logic               special_q, border_q, last_col_q;

  assign ra = rdata_a;
  assign rb = rdata_b;

  always_comb begin
    wline.dep_two = ra.dep_up;
    wline.dep_up  = dep_q;
    wline.bef_up  = prv_q;
    wline.now_two = ra.now_up;
    wline.now_up  = cur_q;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      wline     = '0;
    end else begin
      ram_we    = (state_q == ST_READ);
      ram_waddr = c_q;
    end
  end

  whs_ram #(
    .WIDTH (whs_pkg::LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (wline),
    .raddr_a_i (c0),
    .raddr_b_i (c0 + CW'(1)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // result queue
  whs_pkg::result_t res_a, res_b, q_data;
  logic [1:0]       q_free, push_n;
  logic signed [46:0] sum;
  logic signed [45:0] term_q;
  logic signed [25:0] base_q;

  always_comb begin
    sum = 47'(base_q) + 47'(term_q);
    if (border_q) begin
      res_a.height_next = '0;
    end else if (!special_q) begin
      if (sum > SAT_MAX) begin
        res_a.height_next = SAT_MAX[23:0];
      end else if (sum < SAT_MIN) begin
        res_a.height_next = SAT_MIN[23:0];
      end else begin
        res_a.height_next = sum[23:0];
      end
    end else begin
      res_a.height_next = src_q;
    end
    res_a.last_of_run = (n_q != 2'd2);
    res_a.frame_end   = 1'b0;
    res_b.height_next = '0;
    res_b.last_of_run = 1'b1;
    res_b.frame_end   = last_col_q;
    push_n = ((state_q == ST_FIN) && (q_free >= n_q)) ? n_q : 2'd0;
  end

  whs_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push_a_i (res_a),
    .push_b_i (res_b),
    .free_o   (q_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (q_data)
  );

  assign m_axis_tdata    = q_data.height_next;
  assign m_axis_tlast    = q_data.last_of_run;
  assign m_axis_tuser[0] = q_data.frame_end;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      upl_now_q <= '0;
      upl_dep_q <= '0;
      n_q       <= 2'd0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(MAX_WIDTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            col_q   <= c1;
            row_q   <= r1;
            n_q     <= n_res;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          upl_now_q <= ra.now_up;
          upl_dep_q <= ra.dep_up;
          if (n_q == 2'd0) begin
            state_q <= ST_IDLE;
          end else if (special_q) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_ADD;
        ST_ADD:  state_q <= ST_FIN;
        ST_FIN: begin
          if (q_free >= n_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  logic signed [27:0] lap_q;
  logic signed [16:0] ddx_q, ddy_q;
  logic signed [24:0] dhx_q, dhy_q;
  logic        [15:0] d0_q;
  logic signed [44:0] p0_q;
  logic signed [41:0] px_q, py_q;
  logic signed [47:0] s_q;
  logic signed [64:0] mh_q;
  logic        [47:0] ml_q;
  logic        [80:0] full;

  // coef * S = coef * S_hi * 2^16 + coef * S_lo, plus half an LSB of the 2^-34 scale
  assign full = (81'(mh_q) << 16) + 81'(ml_q) + RND_HALF;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q      <= $signed(s_axis_tdata[23:0]);
      prv_q      <= $signed(s_axis_tdata[47:24]);
      dep_q      <= s_axis_tdata[63:48];
      src_q      <= $signed(s_axis_tdata[87:64]);
      c_q        <= c0;
      border_q   <= border;
      special_q  <= border || source;
      last_col_q <= last_col;
    end
    if (state_q == ST_READ) begin
      lap_q  <= 28'(cur_q) + 28'(ra.now_two) + 28'(rb.now_up) + 28'(upl_now_q)
                - (28'(ra.now_up) <<< 2);
      ddx_q  <= $signed({1'b0, rb.dep_up}) - $signed({1'b0, upl_dep_q});
      dhx_q  <= 25'(rb.now_up) - 25'(upl_now_q);
      ddy_q  <= $signed({1'b0, dep_q}) - $signed({1'b0, ra.dep_two});
      dhy_q  <= 25'(cur_q) - 25'(ra.now_two);
      base_q <= (26'(ra.now_up) <<< 1) - 26'(ra.bef_up);
      d0_q   <= ra.dep_up;
    end
    if (state_q == ST_MUL1) begin
      p0_q <= $signed({1'b0, d0_q}) * lap_q;
      px_q <= ddx_q * dhx_q;
      py_q <= ddy_q * dhy_q;
    end
    if (state_q == ST_SUM) begin
      s_q <= (48'(p0_q) <<< 2) + 48'(px_q) + 48'(py_q);
    end
    if (state_q == ST_MUL2) begin
      mh_q <= $signed({1'b0, coef_q}) * $signed(s_q[47:16]);
      ml_q <= coef_q * s_q[15:0];
    end
    if (state_q == ST_ADD) begin
      term_q <= full[79:34];
    end
  end

`ifndef SYNTH
  a_one_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request taken while a cell is in flight");

  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (q_free == 2'd2))
    else $error("two results pushed into a non-empty queue");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_axis_tvalid)
    else $error("result offered during clearing pass");

  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("frame end without end of run");
`endif

endmodule

`default_nettype wire
